/* sv/i2fx_pkg.sv */
// Package for the IEEE-754 to 32.32 fixed-point converter.
// Holds status codes, format constants and the per-stage control struct.
// No dependencies.
package i2fx_pkg;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NAN     = 3'd1,
		ST_POS_INF = 3'd2,
		ST_NEG_INF = 3'd3,
		ST_POS_OVF = 3'd4,
		ST_NEG_OVF = 3'd5
	} status_t;

	// Configuration register indexes
	localparam logic CFG_FORMAT_DOUBLE  = 1'b0;
	localparam logic CFG_BYTE_ORDER_MAP = 1'b1;

	// Register reset values
	localparam logic        FORMAT_DOUBLE_RST  = 1'b1;
	localparam logic [23:0] BYTE_ORDER_MAP_RST = 24'hFAC688;

	// Format constants; exponent math is done in 13-bit signed
	localparam logic signed [12:0] DBL_BIAS   = 13'sd1023;
	localparam logic signed [12:0] SGL_BIAS   = 13'sd127;
	localparam logic signed [12:0] DBL_MAXEXP = 13'sd31;
	localparam logic signed [12:0] SGL_MAXEXP = 13'sd30;
	localparam logic signed [12:0] DBL_OFFS   = -13'sd20;
	localparam logic signed [12:0] SGL_OFFS   = 13'sd9;
	localparam logic [10:0]        DBL_MAXCHR = 11'd2047;
	localparam logic [10:0]        SGL_MAXCHR = 11'd255;
	localparam int                 MANT_W     = 53;

	localparam logic [3:0] USED_DOUBLE = 4'd8;
	localparam logic [3:0] USED_SINGLE = 4'd4;

	// Control word that travels with the mantissa after decode
	typedef struct packed {
		logic       neg;
		logic       dbl;
		logic       zero;
		logic       shl;
		logic [5:0] amt;
		status_t    st;
	} ctl_t;

endpackage

/* sv/ieee754_to_fixed_point_unit.sv */
// IEEE-754 single/double to signed 32.32 fixed-point converter, top level.
// Depends on i2fx_pkg for status codes, format constants and ctl_t.
//
// Usage:
//   Input channel in_valid/in_stall carries raw_bytes (eight bytes, byte k
//   at bits 8k+7..8k). Output channel out_valid/out_stall carries
//   fixed_value, status and bytes_used. An item moves at a clock edge with
//   valid high and stall low.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 = format_double, 1 = byte_order_map). Write only while idle.
//   Pipeline: byte reorder, field decode, barrel shift, negate. An item
//   accepted at the input is registered in stages 1, 2, 3 and 4 in turn,
//   stage 4 driving the output, and one item can enter every cycle while
//   the output is not stalled.
//   When the receiver stalls, the output holds and stages fill up behind
//   it; in_stall rises only once the first stage is full and cannot move.
//   Nothing is lost or repeated.
//   Reset clears all valid bits and loads format_double = 1 and the
//   identity byte map.
module ieee754_to_fixed_point_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] raw_bytes,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] fixed_value,
	output logic [2:0]  status,
	output logic [3:0]  bytes_used
);
	import i2fx_pkg::*;

	// Configuration registers
	logic        format_double_q;
	logic [23:0] byte_order_map_q;

	// Stage registers
	logic                valid_s1, valid_s2, valid_s3, valid_s4;
	logic [7:0]          fbyte_s1 [8];
	logic                dbl_s1;
	logic [MANT_W-1:0]   mant_s2;
	ctl_t                ctl_s2, ctl_s3;
	logic [63:0]         mag_s3;
	logic [63:0]         value_s4;
	status_t             st_s4;
	logic                dbl_s4;

	logic adv_s1, adv_s2, adv_s3, adv_s4;

	// Each stage moves when empty or when the next one moves
	assign adv_s4   = !valid_s4 || !out_stall;
	assign adv_s3   = !valid_s3 || adv_s4;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_double_q  <= FORMAT_DOUBLE_RST;
			byte_order_map_q <= BYTE_ORDER_MAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FORMAT_DOUBLE:  format_double_q  <= cfg_data[0];
				CFG_BYTE_ORDER_MAP: byte_order_map_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: reorder bytes through the map
	logic [7:0] fbyte_c [8];
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			fbyte_c[i] = raw_bytes[{byte_order_map_q[3*i +: 3], 3'b000} +: 8];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			fbyte_s1 <= fbyte_c;
			dbl_s1   <= format_double_q;
		end
	end

	// Stage 2: split fields, classify, work out shift direction and amount
	logic [10:0]              chr_c;
	logic [MANT_W-1:0]        mant_c;
	logic signed [12:0]       exp_c, shift_c, rneg_c;
	logic                     mant_nz_c, is_max_c, is_ovf_c;
	ctl_t                     ctl_c;

	always_comb begin
		if (dbl_s1) begin
			chr_c  = {fbyte_s1[0][6:0], fbyte_s1[1][7:4]};
			mant_c = {1'b0, fbyte_s1[1][3:0], fbyte_s1[2], fbyte_s1[3], fbyte_s1[4],
				fbyte_s1[5], fbyte_s1[6], fbyte_s1[7]};
			exp_c    = $signed({2'b00, chr_c}) - DBL_BIAS;
			shift_c  = exp_c + DBL_OFFS;
			is_max_c = (chr_c == DBL_MAXCHR);
			is_ovf_c = (exp_c > DBL_MAXEXP);
		end else begin
			chr_c  = {3'b000, fbyte_s1[0][6:0], fbyte_s1[1][7]};
			mant_c = {30'd0, fbyte_s1[1][6:0], fbyte_s1[2], fbyte_s1[3]};
			exp_c    = $signed({2'b00, chr_c}) - SGL_BIAS;
			shift_c  = exp_c + SGL_OFFS;
			is_max_c = (chr_c == SGL_MAXCHR);
			is_ovf_c = (exp_c > SGL_MAXEXP);
		end
		mant_nz_c = (mant_c != '0);
		rneg_c    = -shift_c;

		ctl_c.neg  = fbyte_s1[0][7];
		ctl_c.dbl  = dbl_s1;
		ctl_c.shl  = !shift_c[12];
		ctl_c.amt  = shift_c[12] ? rneg_c[5:0] : shift_c[5:0];
		ctl_c.zero = 1'b0;
		ctl_c.st   = ST_OK;
		if (is_max_c) begin
			ctl_c.zero = 1'b1;
			ctl_c.st   = mant_nz_c ? ST_NAN : (ctl_c.neg ? ST_NEG_INF : ST_POS_INF);
		end else if (is_ovf_c) begin
			ctl_c.zero = 1'b1;
			ctl_c.st   = ctl_c.neg ? ST_NEG_OVF : ST_POS_OVF;
		end else if (chr_c == 11'd0) begin
			// zeros and denormals
			ctl_c.zero = 1'b1;
		end else if (shift_c[12] && (rneg_c[12:6] != 7'd0)) begin
			// right shift of 64 or more
			ctl_c.zero = 1'b1;
		end

		// add the implied one
		if (dbl_s1) begin
			mant_c[52] = 1'b1;
		end else begin
			mant_c[23] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			mant_s2 <= mant_c;
			ctl_s2  <= ctl_c;
		end
	end

	// Stage 3: barrel shift the mantissa into 32.32 position
	logic [63:0] mant_ext_c, mag_c;
	always_comb begin
		mant_ext_c = {{(64-MANT_W){1'b0}}, mant_s2};
		if (ctl_s2.zero) begin
			mag_c = '0;
		end else if (ctl_s2.shl) begin
			mag_c = mant_ext_c << ctl_s2.amt;
		end else begin
			mag_c = mant_ext_c >> ctl_s2.amt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			mag_s3 <= mag_c;
			ctl_s3 <= ctl_s2;
		end
	end

	// Stage 4: apply the sign; this is the output register
	always_ff @(posedge clk) begin
		if (adv_s4 && valid_s3) begin
			value_s4 <= ctl_s3.neg ? (64'd0 - mag_s3) : mag_s3;
			st_s4    <= ctl_s3.st;
			dbl_s4   <= ctl_s3.dbl;
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
		end
	end

	assign out_valid   = valid_s4;
	assign fixed_value = value_s4;
	assign status      = st_s4;
	assign bytes_used  = dbl_s4 ? USED_DOUBLE : USED_SINGLE;

	// Any error status comes with a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> fixed_value == 64'd0)
		else $error("error status with nonzero value");

	// Bytes used is always one of the two formats
	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (bytes_used == USED_SINGLE) || (bytes_used == USED_DOUBLE))
		else $error("bad bytes_used");

	// Input is held off only when every stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && valid_s3 && valid_s4)
		else $error("input stalled with room in the pipeline");

	// A blocked middle stage keeps its item
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !adv_s3 |=> valid_s3 && $stable(mag_s3))
		else $error("stage 3 lost its item under stall");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for ieee754_to_fixed_point_unit: float words in, 32.32 values out.
// Depends on i2fx_pkg for status codes, register indexes and reset values.
module tb_top;
	import i2fx_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 150;
	localparam int NUM_PHASES  = 12;
	localparam int PHASE_ITEMS = 100;

	// One converted result as it leaves the block
	typedef struct packed {
		logic [63:0] value;
		status_t     st;
		logic [3:0]  used;
	} fixed_result_t;

	// Predict conversions and compare them against the output stream
	class conv_scoreboard;
		bit            fmt_dbl;
		logic [23:0]   byte_map;
		fixed_result_t expected_fixed[$];
		int            mismatches;

		function new();
			fmt_dbl    = FORMAT_DOUBLE_RST;
			byte_map   = BYTE_ORDER_MAP_RST;
			mismatches = 0;
		endfunction

		function fixed_result_t to_fixed(logic [63:0] raw);
			logic [7:0]    fb [8];
			logic [2:0]    src;
			logic [63:0]   mant;
			logic [63:0]   value;
			logic          neg;
			int            chr, bias, maxchr, maxexp, mbits, offs, expo, sh;
			fixed_result_t r;
			// reorder buffer bytes into format bytes
			for (int i = 0; i < 8; i++) begin
				src   = byte_map[3*i +: 3];
				fb[i] = raw[8*src +: 8];
			end
			neg = fb[0][7];
			if (fmt_dbl) begin
				chr    = int'({fb[0][6:0], fb[1][7:4]});
				mant   = {12'd0, fb[1][3:0], fb[2], fb[3], fb[4], fb[5], fb[6], fb[7]};
				bias   = int'(DBL_BIAS);
				maxchr = int'(DBL_MAXCHR);
				maxexp = int'(DBL_MAXEXP);
				offs   = int'(DBL_OFFS);
				mbits  = 52;
				r.used = USED_DOUBLE;
			end else begin
				chr    = int'({fb[0][6:0], fb[1][7]});
				mant   = {41'd0, fb[1][6:0], fb[2], fb[3]};
				bias   = int'(SGL_BIAS);
				maxchr = int'(SGL_MAXCHR);
				maxexp = int'(SGL_MAXEXP);
				offs   = int'(SGL_OFFS);
				mbits  = 23;
				r.used = USED_SINGLE;
			end
			expo  = chr - bias;
			sh    = expo + offs;
			value = '0;
			r.st  = ST_OK;
			if (chr == maxchr) begin
				if (mant != 0)
					r.st = ST_NAN;
				else
					r.st = neg ? ST_NEG_INF : ST_POS_INF;
			end else if (expo > maxexp) begin
				r.st = neg ? ST_NEG_OVF : ST_POS_OVF;
			end else if (chr != 0) begin
				// add the implied one, align to the binary point, apply sign
				mant[mbits] = 1'b1;
				if (sh >= 0)
					value = mant << sh;
				else if (-sh < 64)
					value = mant >> (-sh);
				if (neg)
					value = -value;
			end
			r.value = value;
			return r;
		endfunction

		function void note_input(logic [63:0] raw);
			expected_fixed.push_back(to_fixed(raw));
		endfunction

		function void check_result(logic [63:0] value, logic [2:0] st, logic [3:0] used);
			fixed_result_t e;
			if (expected_fixed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected item value=%h status=%0d used=%0d",
						$realtime, value, st, used);
				return;
			end
			e = expected_fixed.pop_front();
			if (value !== e.value || st !== e.st || used !== e.used) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: mismatch value exp=%h got=%h ",
						"status exp=%0d got=%0d used exp=%0d got=%0d"},
						$realtime, e.value, value, e.st, st, e.used, used);
			end
		endfunction

		function int pending();
			return expected_fixed.size();
		endfunction

		function bit failed();
			return mismatches != 0 || expected_fixed.size() != 0;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] raw_bytes;
	logic        cfg_we;
	logic        cfg_index;
	logic [23:0] cfg_data;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] fixed_value;
	logic [2:0]  status;
	logic [3:0]  bytes_used;

	conv_scoreboard sb;
	bit             idle_on;
	bit             long_hold_req;
	bit             cur_dbl;
	logic [23:0]    cur_map;
	int             cycles;

	ieee754_to_fixed_point_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.raw_bytes  (raw_bytes),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.fixed_value(fixed_value),
		.status     (status),
		.bytes_used (bytes_used)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Record accepted items and check delivered results
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_input(raw_bytes);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(fixed_value, status, bytes_used);
	end

	// Receiver: random stall bursts, plus one long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one item, optionally after an idle burst; return at the next falling edge
	task automatic send_item(input logic [63:0] raw);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid  <= 1'b1;
		raw_bytes <= raw;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Hold off until every expected result has come back
	task automatic drain();
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [23:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_FORMAT_DOUBLE) begin
			cur_dbl    = data[0];
			sb.fmt_dbl = data[0];
		end else begin
			cur_map     = data;
			sb.byte_map = data;
		end
		@(negedge clk);
	endtask

	// Scatter a big-endian format word into buffer bytes through the current map
	function automatic logic [63:0] scatter(logic [63:0] word);
		logic [63:0] raw;
		logic [2:0]  src;
		raw = {$urandom, $urandom};
		// go high to low so the sign and exponent bytes win on collisions
		for (int i = 7; i >= 0; i--) begin
			src = cur_map[3*i +: 3];
			raw[8*src +: 8] = word[63 - 8*i -: 8];
		end
		return raw;
	endfunction

	function automatic logic [63:0] float_word(logic sign, int expf, logic [51:0] mant);
		if (cur_dbl)
			return {sign, expf[10:0], mant};
		return {sign, expf[7:0], mant[22:0], $urandom};
	endfunction

	task automatic send_float(input logic sign, input int expf, input logic [51:0] mant);
		send_item(scatter(float_word(sign, expf, mant)));
	endtask

	// Random item, weighted toward in-range values with rarer special cases
	function automatic logic [63:0] random_raw();
		int          cat, bias, maxchr, expf;
		logic        sign;
		logic [51:0] mant;
		cat    = $urandom_range(0, 99);
		sign   = 1'($urandom_range(0, 1));
		bias   = cur_dbl ? 1023 : 127;
		maxchr = cur_dbl ? 2047 : 255;
		case ($urandom_range(0, 9))
			0:       mant = '0;
			1:       mant = '1;
			default: mant = 52'({$urandom, $urandom});
		endcase
		if (cat < 5)
			return {$urandom, $urandom};
		if (cat < 70)
			expf = cur_dbl ? bias + $urandom_range(0, 103) - 70
				: bias + $urandom_range(0, 74) - 42;
		else if (cat < 78)
			expf = 0;
		else if (cat < 86)
			expf = maxchr;
		else if (cat < 92)
			expf = $urandom_range(0, maxchr);
		else
			expf = bias + (cur_dbl ? 28 : 27) + $urandom_range(0, 5);
		if (cat >= 78 && cat < 82)
			mant = '0;
		return scatter(float_word(sign, expf, mant));
	endfunction

	function automatic logic [23:0] shuffled_map();
		int          ent [8];
		int          j, t;
		logic [23:0] m;
		for (int i = 0; i < 8; i++) ent[i] = i;
		for (int i = 7; i > 0; i--) begin
			j      = $urandom_range(0, i);
			t      = ent[i];
			ent[i] = ent[j];
			ent[j] = t;
		end
		for (int i = 0; i < 8; i++) m[3*i +: 3] = 3'(ent[i]);
		return m;
	endfunction

	// Main sequence
	initial begin
		logic [23:0] map;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		raw_bytes     = '0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_FORMAT_DOUBLE;
		cfg_data      = '0;
		out_stall     = 1'b0;
		idle_on       = 1'b1;
		long_hold_req = 1'b0;
		cycles        = 0;
		cur_dbl       = FORMAT_DOUBLE_RST;
		cur_map       = BYTE_ORDER_MAP_RST;
		sb            = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Double edge cases under reset settings
		send_float(0, 0, '0);
		send_float(1, 0, '0);
		send_float(0, 1023, '0);
		send_float(1, 1023, 52'h8_0000_0000_0000);
		send_float(0, 1054, '1);
		send_float(1, 1054, '1);
		send_float(0, 1055, '0);
		send_float(1, 1055, 52'd5);
		send_float(0, 2047, '0);
		send_float(1, 2047, '0);
		send_float(0, 2047, 52'd1);
		send_float(1, 0, '1);
		send_float(0, 979, '1);
		send_item('1);
		stop_sending();
		drain();

		// Single edge cases
		write_reg(CFG_FORMAT_DOUBLE, 24'd0);
		send_float(1, 0, '0);
		send_float(0, 127, '0);
		send_float(0, 157, '1);
		send_float(1, 157, '1);
		send_float(0, 158, '0);
		send_float(1, 158, '0);
		send_float(1, 255, '0);
		send_float(0, 255, 52'h40_0000);
		send_float(0, 0, '1);
		send_float(1, 54, '1);
		send_item('0);
		stop_sending();
		drain();

		// Random phases over maps and formats
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0:       map = 24'h000000;
				1:       map = 24'hFFFFFF;
				2:       map = 24'h053977;
				3:       map = 24'hFAC053;
				4:       map = BYTE_ORDER_MAP_RST;
				default: map = (p % 3 == 0) ? 24'($urandom) : shuffled_map();
			endcase
			write_reg(CFG_BYTE_ORDER_MAP, map);
			write_reg(CFG_FORMAT_DOUBLE, {23'($urandom), (p % 2 == 0) ? 1'b1 : 1'b0});
			if (p == 4) begin
				// fill the pipe against a long output stall
				idle_on       = 1'b0;
				long_hold_req = 1'b1;
				repeat (40) send_item(random_raw());
				stop_sending();
				drain();
			end
			idle_on = (p != NUM_PHASES - 1);
			repeat (PHASE_ITEMS) send_item(random_raw());
			stop_sending();
			drain();
		end

		repeat (8) @(negedge clk);
		if (sb.failed())
			$display("RESULT: ERROR");
		else
			$display("RESULT: OK");
		$finish;
	end

endmodule
